@@ design/rle_pkg.sv @@
`timescale 1ns / 1ps
// rle_pkg: constants, types and the run code function of the byte run-length encoder.
// No dependencies; used by rle_run, rle_obuf, rle_byte_encoder and the bench.
package rle_pkg;

	localparam int unsigned RLE_MAX_RUN = 63;
	localparam int unsigned RUN_W       = 6;
	localparam int unsigned BURST_MAX   = 5;
	localparam int unsigned BCNT_W      = 3;

	localparam logic [7:0] RUN_MARK = 8'hC0;
	localparam logic [7:0] END_MARK = 8'hC0;

	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
	} rle_pair_t;

	typedef struct packed {
		logic [BCNT_W-1:0]             cnt;
		logic [BURST_MAX-1:0][7:0]     bytes;
	} rle_burst_t;

	function automatic rle_pair_t run_code(logic [7:0] v, logic [RUN_W-1:0] l);
		rle_pair_t p;
		p.b1 = v;
		if (l > RUN_W'(1) || (v & RUN_MARK) == RUN_MARK) begin
			p.cnt = 2'd2;
			p.b0  = RUN_MARK | {2'b00, l};
		end else begin
			p.cnt = 2'd1;
			p.b0  = v;
		end
		return p;
	endfunction

endpackage

@@ design/rle_in_if.sv @@
`timescale 1ns / 1ps
// rle_in_if: input channel of the encoder, one raw byte per item.
// Standalone; no package needed.
interface rle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ design/rle_out_if.sv @@
`timescale 1ns / 1ps
// rle_out_if: output channel of the encoder, one coded byte per item.
// Standalone; no package needed.
interface rle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

@@ design/rle_run.sv @@
`timescale 1ns / 1ps
// rle_run: input register, run state and coding of one item into a burst of up to five bytes.
// Depends on rle_pkg and rle_in_if.
module rle_run
	import rle_pkg::*;
#(
	parameter int unsigned MAX_RUN = RLE_MAX_RUN
) (
	input  logic        clk,
	input  logic        arst_n,
	rle_in_if.sink      din,
	input  logic        buf_free,
	output logic        burst_valid,
	output rle_burst_t  burst
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic [7:0]           held_q;
	logic [RUN_W-1:0]     len_q;
	logic                 consume;
	logic                 close;
	logic                 fresh;
	logic [7:0]           nv;
	logic [RUN_W-1:0]     nl;
	rle_pair_t            p_close;
	rle_pair_t            p_flush;
	logic [BCNT_W-1:0]    n;
	rle_burst_t           bl;

	assign close   = (len_q != '0) &&
	                 !(byte_s1 == held_q && len_q < RUN_W'(MAX_RUN));
	assign fresh   = (len_q == '0) || close;
	assign nv      = fresh ? byte_s1 : held_q;
	assign nl      = fresh ? RUN_W'(1) : len_q + RUN_W'(1);
	assign p_close = run_code(held_q, len_q);
	assign p_flush = run_code(nv, nl);

	always_comb begin
		n        = '0;
		bl.bytes = '0;
		if (close) begin
			bl.bytes[0] = p_close.b0;
			bl.bytes[1] = p_close.b1;
			n           = BCNT_W'(p_close.cnt);
		end
		if (last_s1) begin
			bl.bytes[n] = p_flush.b0;
			if (p_flush.cnt == 2'd2) begin
				bl.bytes[n + BCNT_W'(1)] = p_flush.b1;
			end
			n           = n + BCNT_W'(p_flush.cnt);
			bl.bytes[n] = END_MARK;
			n           = n + BCNT_W'(1);
		end
		bl.cnt = n;
	end

	assign burst       = bl;
	assign burst_valid = valid_s1 && (bl.cnt != '0);
	assign consume     = valid_s1 && ((bl.cnt == '0) || buf_free);
	assign din.ready   = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			byte_s1 <= din.in_byte;
			last_s1 <= din.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			len_q  <= '0;
		end else if (consume) begin
			if (last_s1) begin
				held_q <= '0;
				len_q  <= '0;
			end else begin
				held_q <= nv;
				len_q  <= nl;
			end
		end
	end

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= RUN_W'(MAX_RUN))
		else $error("run length above limit");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_s1 |=> len_q == '0)
		else $error("run not cleared after final byte");

endmodule

@@ design/rle_obuf.sv @@
`timescale 1ns / 1ps
// rle_obuf: result register that sends a burst of coded bytes one per cycle
// while dout is ready. Depends on rle_pkg and rle_out_if.
module rle_obuf
	import rle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        burst_valid,
	input  rle_burst_t  burst,
	output logic        buf_free,
	rle_out_if.source   dout
);

	logic [BCNT_W-1:0]          cnt_q;
	logic [BURST_MAX-1:0][7:0]  slots_q;
	logic                       load;
	logic                       take;

	assign take          = dout.valid && dout.ready;
	assign buf_free      = (cnt_q == '0) || (cnt_q == BCNT_W'(1) && dout.ready);
	assign load          = burst_valid && buf_free;
	assign dout.valid    = cnt_q != '0;
	assign dout.out_byte = slots_q[0];
	assign dout.out_last = cnt_q == BCNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - BCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slots_q <= burst.bytes;
		end else if (take) begin
			slots_q <= {8'h00, slots_q[BURST_MAX-1:1]};
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= BCNT_W'(BURST_MAX))
		else $error("burst count above limit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q > BCNT_W'(1) |=> cnt_q != '0)
		else $error("pending bytes dropped");

endmodule

@@ design/rle_byte_encoder.sv @@
`timescale 1ns / 1ps
// channel | dir | payload           | meaning
// din     | in  | in_byte, in_last  | raw byte, flag on final byte of stream
// dout    | out | out_byte, out_last | coded byte, flag on last byte of an item
// An item is registered on accept and coded the next cycle into a burst of 0..5 bytes.
// The result register sends one byte per cycle while dout is ready; a new item enters
// every cycle while bursts are empty, else as the last byte of a burst goes out.
// Items pass the input register, then the result register. Stalls on dout hold both stages.
// Reset clears the run state and both stages; no clearing pass is needed.
// Top level of the byte run-length encoder. Depends on rle_pkg, rle_in_if, rle_out_if,
// rle_run and rle_obuf.
module rle_byte_encoder
	import rle_pkg::*;
#(
	parameter int unsigned MAX_RUN = RLE_MAX_RUN
) (
	input  logic      clk,
	input  logic      arst_n,
	rle_in_if.sink    din,
	rle_out_if.source dout
);

	logic       buf_free;
	logic       burst_valid;
	rle_burst_t burst;

	rle_run #(
		.MAX_RUN (MAX_RUN)
	) u_run (
		.clk         (clk),
		.arst_n      (arst_n),
		.din         (din),
		.buf_free    (buf_free),
		.burst_valid (burst_valid),
		.burst       (burst)
	);

	rle_obuf u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_valid (burst_valid),
		.burst       (burst),
		.buf_free    (buf_free),
		.dout        (dout)
	);

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for rle_byte_encoder, directed rows then random byte streams.
// Depends on rle_pkg, rle_in_if, rle_out_if and the encoder RTL; a local run coder predicts
// untyped items, typed rows list theirs; each output item is checked in order against them.
module tb_top;
	import rle_pkg::*;

	localparam int unsigned RUN_LIMIT = RLE_MAX_RUN;
	localparam int          NDIR      = 20;
	localparam int          PHASE_ITEMS = 35;
	localparam int          HOLD_CYCLES = 200;
	localparam int          STALL_LIMIT = 2000;
	localparam int          TAIL_CYCLES = 10;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} coded_t;

	typedef struct packed {
		logic [7:0]      b;
		logic            fin;
		logic            typed;
		logic [2:0]      n;
		logic [0:4][7:0] codes;
	} step_t;

	logic clk;
	logic arst_n;

	rle_in_if  din_if ();
	rle_out_if dout_if ();

	rle_byte_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	coded_t     code_q[$];
	coded_t     burst[$];
	logic [7:0] run_val;
	logic [5:0] run_len;
	step_t      dir_tab [NDIR];
	int         tx_idle;
	int         rx_idle;
	int         hold_reqs;
	int         fails;
	int         stall_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic coded_t mk_code(input logic [7:0] v, input logic l);
		coded_t c;
		c.out_byte = v;
		c.out_last = l;
		return c;
	endfunction

	function automatic step_t mk_step(input logic [7:0] b, input logic fin, input logic typed,
			input logic [2:0] n, input logic [0:4][7:0] codes);
		step_t s;
		s.b     = b;
		s.fin   = fin;
		s.typed = typed;
		s.n     = n;
		s.codes = codes;
		return s;
	endfunction

	function automatic void close_run();
		if (run_len > 6'd1 || (run_val & RUN_MARK) == RUN_MARK)
			burst.push_back(mk_code(RUN_MARK | {2'b00, run_len}, 1'b0));
		burst.push_back(mk_code(run_val, 1'b0));
	endfunction

	function automatic void code_byte(input logic [7:0] b, input logic fin);
		burst.delete();
		if (run_len == 6'd0) begin
			run_val = b;
			run_len = 6'd1;
		end else if (b == run_val && run_len < RUN_LIMIT) begin
			run_len = run_len + 6'd1;
		end else begin
			close_run();
			run_val = b;
			run_len = 6'd1;
		end
		if (fin) begin
			close_run();
			burst.push_back(mk_code(END_MARK, 1'b0));
			run_val = 8'h00;
			run_len = 6'd0;
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].out_last = 1'b1;
	endfunction

	task automatic send_item(input logic [7:0] b, input logic fin, input logic typed,
			input logic [2:0] n, input logic [0:4][7:0] codes);
		while ($urandom_range(0, 99) < tx_idle) begin
			din_if.valid <= 1'b0;
			@(negedge clk);
		end
		din_if.valid   <= 1'b1;
		din_if.in_byte <= b;
		din_if.in_last <= fin;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		code_byte(b, fin);
		if (typed) begin
			for (int i = 0; i < n; i++)
				code_q.push_back(mk_code(codes[i], i == n - 1));
		end else begin
			foreach (burst[i])
				code_q.push_back(burst[i]);
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		din_if.valid <= 1'b0;
		while (code_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// receiver: random ready, with a long hold-off on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen     = 0;
		hold_left     = 0;
		dout_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				dout_if.ready <= 1'b0;
			end else if (hold_left != 0) begin
				dout_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_seen != hold_reqs) begin
				hold_seen     = hold_reqs;
				hold_left     = HOLD_CYCLES - 1;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= ($urandom_range(0, 99) >= rx_idle);
			end
		end
	end

	always @(posedge clk) begin
		coded_t want;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (code_q.size() == 0) begin
				$error("out_byte: no item expected, actual %02h", dout_if.out_byte);
				fails++;
			end else begin
				want = code_q.pop_front();
				if (dout_if.out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, actual %02h", want.out_byte,
						dout_if.out_byte);
					fails++;
				end
				if (dout_if.out_last !== want.out_last) begin
					$error("out_last: expected %0b, actual %0b", want.out_last,
						dout_if.out_last);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int         sent;
		int         nruns;
		int         len;
		logic [7:0] v;
		logic [7:0] b;
		arst_n         = 1'b0;
		din_if.valid   = 1'b0;
		din_if.in_byte = 8'h00;
		din_if.in_last = 1'b0;
		run_val        = 8'h00;
		run_len        = 6'd0;
		tx_idle        = 29;
		rx_idle        = 59;
		hold_reqs      = 0;
		fails          = 0;
		stall_cycles   = 0;

		dir_tab[0]  = mk_step(8'h00, 1'b1, 1'b1, 3'd2, {8'h00, 8'hC0, 8'h00, 8'h00, 8'h00});
		dir_tab[1]  = mk_step(8'hFF, 1'b1, 1'b1, 3'd3, {8'hC1, 8'hFF, 8'hC0, 8'h00, 8'h00});
		dir_tab[2]  = mk_step(8'hC0, 1'b1, 1'b1, 3'd3, {8'hC1, 8'hC0, 8'hC0, 8'h00, 8'h00});
		dir_tab[3]  = mk_step(8'h3F, 1'b0, 1'b1, 3'd0, '0);
		dir_tab[4]  = mk_step(8'h3F, 1'b0, 1'b1, 3'd0, '0);
		dir_tab[5]  = mk_step(8'h40, 1'b0, 1'b0, 3'd0, '0);
		dir_tab[6]  = mk_step(8'h80, 1'b1, 1'b0, 3'd0, '0);
		dir_tab[7]  = mk_step(8'hFF, 1'b0, 1'b1, 3'd0, '0);
		dir_tab[8]  = mk_step(8'hFF, 1'b1, 1'b1, 3'd3, {8'hC2, 8'hFF, 8'hC0, 8'h00, 8'h00});
		dir_tab[9]  = mk_step(8'h11, 1'b0, 1'b1, 3'd0, '0);
		dir_tab[10] = mk_step(8'h11, 1'b0, 1'b1, 3'd0, '0);
		dir_tab[11] = mk_step(8'hD0, 1'b1, 1'b0, 3'd0, '0);
		dir_tab[12] = mk_step(8'h7F, 1'b0, 1'b1, 3'd0, '0);
		dir_tab[13] = mk_step(8'h00, 1'b0, 1'b0, 3'd0, '0);
		dir_tab[14] = mk_step(8'h01, 1'b0, 1'b0, 3'd0, '0);
		dir_tab[15] = mk_step(8'hBF, 1'b0, 1'b0, 3'd0, '0);
		dir_tab[16] = mk_step(8'hC1, 1'b0, 1'b0, 3'd0, '0);
		dir_tab[17] = mk_step(8'hC1, 1'b0, 1'b0, 3'd0, '0);
		dir_tab[18] = mk_step(8'h3E, 1'b1, 1'b0, 3'd0, '0);
		dir_tab[19] = mk_step(8'h80, 1'b1, 1'b1, 3'd2, {8'h80, 8'hC0, 8'h00, 8'h00, 8'h00});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < NDIR; i++)
			send_item(dir_tab[i].b, dir_tab[i].fin, dir_tab[i].typed, dir_tab[i].n,
				dir_tab[i].codes);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 29 : (ph == 1) ? 59 : 0;
			rx_idle = (ph == 0) ? 59 : (ph == 1) ? 29 : 0;
			if (ph == 1)
				hold_reqs++;
			// run past the length limit, then end the stream
			if (ph == 2)
				for (int k = 0; k < 64; k++)
					send_item(8'hC5, k == 63, 1'b0, 3'd0, '0);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 15) begin
					b = 8'($urandom_range(0, 255));
					send_item(b, $urandom_range(0, 3) == 0, 1'b0, 3'd0, '0);
					sent++;
				end else begin
					nruns = $urandom_range(1, 6);
					for (int r = 0; r < nruns; r++) begin
						case ($urandom_range(0, 9))
							0: v = 8'h00;
							1: v = 8'hFF;
							2: v = {2'b11, 6'($urandom_range(0, 63))};
							default: v = 8'($urandom_range(0, 255));
						endcase
						case ($urandom_range(0, 19))
							0: len = $urandom_range(60, 70);
							1, 2, 3, 4: len = $urandom_range(2, 8);
							default: len = 1;
						endcase
						for (int k = 0; k < len; k++)
							send_item(v, (r == nruns - 1) && (k == len - 1), 1'b0, 3'd0, '0);
						sent += len;
					end
				end
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
